### rtl/wlh_pkg.sv
package wlh_pkg;

  // defaults for the top-level parameters
  localparam int MAX_WORD_LEN_DEF = 18;
  localparam int COUNT_BITS_DEF   = 20;

  // fixed field widths of the result word
  localparam int FIELD_BITS   = 20;
  localparam int BIN_LEN_BITS = 7;
  localparam int CHAR_BITS    = 8;
  localparam int BAR_BITS     = 8;

  localparam logic [BAR_BITS-1:0] MAX_BAR_WIDTH_RESET = 8'd60;

  // op codes
  localparam logic OP_TEXT = 1'b0;
  localparam logic OP_END  = 1'b1;

  // character codes
  localparam logic [CHAR_BITS-1:0] CHAR_UP_A = 8'h41;
  localparam logic [CHAR_BITS-1:0] CHAR_UP_Z = 8'h5A;
  localparam logic [CHAR_BITS-1:0] CHAR_LO_A = 8'h61;
  localparam logic [CHAR_BITS-1:0] CHAR_LO_Z = 8'h7A;
  localparam logic [CHAR_BITS-1:0] CHAR_APOS = 8'h27;

endpackage

### rtl/word_length_histogram.sv
// Word length histogram. Text words (op 0, one byte in char_code) are taken one per
// cycle while busy is low; letters of either case form words, one apostrophe right
// after letters continues a word without adding to its length. Each finished word
// bumps a saturating bin in an on-chip RAM (bins 1..MAX_WORD_LEN plus an overflow bin).
// An end-of-text word (op 1) closes any open word and starts the readout: busy rises
// and MAX_WORD_LEN+1 results follow, each on the result ports for one cycle under
// result_strobe, overflow bin last with last set. The receiver cannot stall, so
// results must be captured as they come. Readout runs a flush and a check state,
// then a scale search when the largest count exceeds max_bar_width, then a read
// and a bar division for each bin; the shared divider produces one quotient bit
// per cycle. All counts clear at the end of readout. max_bar_width may be written
// only while idle; 0 acts as 1.
module word_length_histogram #(
  parameter int MAX_WORD_LEN = wlh_pkg::MAX_WORD_LEN_DEF,
  parameter int COUNT_BITS   = wlh_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 op,
  input  logic [wlh_pkg::CHAR_BITS-1:0]        char_code,
  input  logic                                 max_bar_width_we,
  input  logic [wlh_pkg::BAR_BITS-1:0]         max_bar_width,
  output logic                                 result_strobe,
  output logic [wlh_pkg::BIN_LEN_BITS-1:0]     bin_length,
  output logic [wlh_pkg::FIELD_BITS-1:0]       word_count,
  output logic [wlh_pkg::FIELD_BITS-1:0]       bar_length,
  output logic [wlh_pkg::FIELD_BITS-1:0]       scale,
  output logic                                 last
);
  import wlh_pkg::*;

  localparam int DEPTH     = MAX_WORD_LEN + 1;   // length bins then overflow bin
  localparam int ADDR_BITS = $clog2(DEPTH);
  localparam logic [ADDR_BITS-1:0]  LAST_IDX  = ADDR_BITS'(MAX_WORD_LEN);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // readout sequencer
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_FLUSH = 4'd1;  // last word write-back lands
  localparam logic [3:0] ST_CHECK = 4'd2;  // compare largest count with limit
  localparam logic [3:0] ST_DIV1  = 4'd3;  // largest / limit
  localparam logic [3:0] ST_CHK2  = 4'd4;
  localparam logic [3:0] ST_DIV2  = 4'd5;  // largest / scale, round scale up if needed
  localparam logic [3:0] ST_READ  = 4'd6;  // read bin
  localparam logic [3:0] ST_BIN   = 4'd7;  // bin data back, start bar division
  localparam logic [3:0] ST_BDIV  = 4'd8;  // bar division, then emit

  logic [3:0]            state;
  logic [ADDR_BITS-1:0]  idx;
  logic [COUNT_BITS-1:0] words_per_unit;
  logic [COUNT_BITS-1:0] largest_count;
  logic [COUNT_BITS-1:0] bin_count;
  logic                  rd_valid;
  logic [DEPTH-1:0]      valid;
  logic [BAR_BITS-1:0]   bar_width;

  logic accept, text_take, flush_take;
  logic rec_en;
  logic [ADDR_BITS-1:0] rec_addr;

  // read-modify-write of one bin
  logic                  wb_pend;
  logic [ADDR_BITS-1:0]  wb_addr;
  logic                  wb_valid;
  logic [COUNT_BITS-1:0] wb_old, wb_new;

  logic                  ram_re;
  logic [ADDR_BITS-1:0]  ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata;

  logic                  div_start, div_done;
  logic [COUNT_BITS-1:0] div_dividend, div_divisor, div_quotient;
  logic [COUNT_BITS-1:0] limit;
  logic [COUNT_BITS-1:0] cur_count;
  logic                  readout_end;

  assign busy       = state != ST_IDLE;
  assign accept     = start && !busy;
  assign text_take  = accept && op == OP_TEXT;
  assign flush_take = accept && op == OP_END;

  assign limit = (bar_width == '0) ? COUNT_BITS'(1) : COUNT_BITS'(bar_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      bar_width <= MAX_BAR_WIDTH_RESET;
    end else if (max_bar_width_we) begin
      bar_width <= max_bar_width;
    end
  end

  wlh_scanner #(
    .MAX_WORD_LEN(MAX_WORD_LEN)
  ) u_scanner (
    .clk       (clk),
    .rst       (rst),
    .text_take (text_take),
    .flush_take(flush_take),
    .char_code (char_code),
    .rec_en    (rec_en),
    .rec_addr  (rec_addr)
  );

  // Two word ends always have a letter between them, so a bump never meets the
  // write-back of the previous one; readout reads start after it too.
  assign ram_re    = rec_en || state == ST_READ;
  assign ram_raddr = rec_en ? rec_addr : idx;

  assign wb_old = wb_valid ? ram_rdata : '0;
  assign wb_new = (wb_old != COUNT_MAX) ? wb_old + COUNT_BITS'(1) : wb_old;

  wlh_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(DEPTH)
  ) u_bins (
    .clk  (clk),
    .we   (wb_pend),
    .waddr(wb_addr),
    .wdata(wb_new),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_pend <= 1'b0;
    end else begin
      wb_pend <= rec_en;
    end
  end

  always_ff @(posedge clk) begin
    wb_addr  <= rec_addr;
    wb_valid <= valid[rec_addr];
  end

  assign readout_end = state == ST_BDIV && div_done && idx == LAST_IDX;

  // per-bin valid bits stand in for clearing the RAM
  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= '0;
      largest_count <= '0;
    end else if (wb_pend) begin
      valid[wb_addr] <= 1'b1;
      if (wb_new > largest_count) begin
        largest_count <= wb_new;
      end
    end else if (readout_end) begin
      valid         <= '0;
      largest_count <= '0;
    end
  end

  assign cur_count = rd_valid ? ram_rdata : '0;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = largest_count;
    div_divisor  = words_per_unit;
    case (state)
      ST_CHECK: begin
        div_start   = largest_count > limit;
        div_divisor = limit;
      end
      ST_CHK2: begin
        div_start = 1'b1;
      end
      ST_BIN: begin
        div_start    = 1'b1;
        div_dividend = cur_count;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  wlh_divider #(
    .WIDTH(COUNT_BITS)
  ) u_divider (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .done    (div_done),
    .quotient(div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (flush_take) begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          state <= (largest_count > limit) ? ST_DIV1 : ST_READ;
        end
        ST_DIV1: begin
          if (div_done) begin
            state <= ST_CHK2;
          end
        end
        ST_CHK2: begin
          state <= ST_DIV2;
        end
        ST_DIV2: begin
          if (div_done) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_BIN;
        end
        ST_BIN: begin
          state <= ST_BDIV;
        end
        ST_BDIV: begin
          if (div_done) begin
            result_strobe <= 1'b1;
            state         <= (idx == LAST_IDX) ? ST_IDLE : ST_READ;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // sequencer payload
  always_ff @(posedge clk) begin
    case (state)
      ST_CHECK: begin
        words_per_unit <= COUNT_BITS'(1);
        idx            <= '0;
      end
      ST_DIV1: begin
        if (div_done) begin
          words_per_unit <= div_quotient;
        end
      end
      ST_DIV2: begin
        if (div_done && div_quotient > limit) begin
          words_per_unit <= words_per_unit + COUNT_BITS'(1);
        end
      end
      ST_READ: begin
        rd_valid <= valid[idx];
      end
      ST_BIN: begin
        bin_count <= cur_count;
      end
      ST_BDIV: begin
        if (div_done) begin
          bin_length <= BIN_LEN_BITS'(idx) + BIN_LEN_BITS'(1);
          word_count <= FIELD_BITS'(bin_count);
          bar_length <= FIELD_BITS'(div_quotient);
          scale      <= FIELD_BITS'(words_per_unit);
          last       <= idx == LAST_IDX;
          idx        <= idx + ADDR_BITS'(1);
        end
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

endmodule

### rtl/wlh_ram.sv
module wlh_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 19
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/wlh_divider.sv
// Restoring divider, one quotient bit per cycle. done pulses with quotient valid.
module wlh_divider #(
  parameter int WIDTH = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quotient
);

  localparam int CNT_BITS = $clog2(WIDTH + 1);

  logic                running;
  logic [CNT_BITS-1:0] count;
  logic [WIDTH-1:0]    rem;
  logic [WIDTH-1:0]    dvs;
  logic [WIDTH:0]      trial;
  logic                fits;

  assign trial = {rem, quotient[WIDTH-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= CNT_BITS'(WIDTH);
      end else if (running) begin
        count <= count - CNT_BITS'(1);
        if (count == CNT_BITS'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (running) begin
      if (fits) begin
        rem <= WIDTH'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[WIDTH-1:0];
      end
      quotient <= {quotient[WIDTH-2:0], fits};
    end
  end

endmodule

### rtl/wlh_scanner.sv
// Word finder: tracks letters, apostrophes and the pending length.
module wlh_scanner #(
  parameter int MAX_WORD_LEN = 18
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   text_take,
  input  logic                                   flush_take,
  input  logic [wlh_pkg::CHAR_BITS-1:0]          char_code,
  output logic                                   rec_en,
  output logic [$clog2(MAX_WORD_LEN+1)-1:0]      rec_addr
);
  import wlh_pkg::*;

  localparam int ADDR_BITS = $clog2(MAX_WORD_LEN + 1);
  localparam int LEN_BITS  = $clog2(MAX_WORD_LEN + 2);

  localparam logic [1:0] SC_OUTSIDE = 2'd0;
  localparam logic [1:0] SC_LETTERS = 2'd1;
  localparam logic [1:0] SC_APOS    = 2'd2;

  localparam logic [LEN_BITS-1:0]  LEN_MAX  = LEN_BITS'(MAX_WORD_LEN);
  localparam logic [ADDR_BITS-1:0] OVF_ADDR = ADDR_BITS'(MAX_WORD_LEN);

  logic [1:0]          scan_state;
  logic [1:0]          scan_state_next;
  logic [LEN_BITS-1:0] pending_length;
  logic [LEN_BITS-1:0] pending_length_next;
  logic                letter;
  logic                word_end;

  // case fold is implicit: both ranges count as letters
  assign letter = char_code inside {[CHAR_UP_A:CHAR_UP_Z], [CHAR_LO_A:CHAR_LO_Z]};

  always_comb begin
    scan_state_next     = scan_state;
    pending_length_next = pending_length;
    word_end            = 1'b0;
    if (flush_take) begin
      word_end            = 1'b1;
      scan_state_next     = SC_OUTSIDE;
      pending_length_next = '0;
    end else if (text_take) begin
      if (letter) begin
        scan_state_next = SC_LETTERS;
        if (pending_length <= LEN_MAX) begin
          pending_length_next = pending_length + LEN_BITS'(1);
        end
      end else if (scan_state == SC_LETTERS && char_code == CHAR_APOS) begin
        scan_state_next = SC_APOS;
      end else begin
        word_end            = scan_state != SC_OUTSIDE;
        scan_state_next     = SC_OUTSIDE;
        pending_length_next = word_end ? '0 : pending_length;
      end
    end
  end

  assign rec_en   = word_end && (pending_length != '0);
  assign rec_addr = (pending_length > LEN_MAX) ? OVF_ADDR
                                               : ADDR_BITS'(pending_length - LEN_BITS'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state     <= SC_OUTSIDE;
      pending_length <= '0;
    end else begin
      scan_state     <= scan_state_next;
      pending_length <= pending_length_next;
    end
  end

endmodule

### rtl/wlh_checker.sv
module wlh_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic                             op,
  input logic                             result_strobe,
  input logic [wlh_pkg::BIN_LEN_BITS-1:0] bin_length,
  input logic [wlh_pkg::FIELD_BITS-1:0]   word_count,
  input logic [wlh_pkg::FIELD_BITS-1:0]   bar_length,
  input logic [wlh_pkg::FIELD_BITS-1:0]   scale,
  input logic                             last
);
  import wlh_pkg::*;

  // end of text always opens a readout
  a_end_starts_readout: assert property (@(posedge clk) disable iff (rst)
    start && !busy && op == OP_END |=> busy)
    else $error("end-of-text word did not start readout");

  // more bins follow while busy
  a_mid_readout_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last |-> busy)
    else $error("readout stopped before the overflow bin");

  // results are spaced by the divider, and scale is shared across one readout
  a_scale_held: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last |=> !result_strobe && $stable(scale))
    else $error("scale changed within a readout");

  a_bar_sane: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> scale != '0 && bar_length <= word_count && bin_length != '0)
    else $error("bar length out of range");

endmodule

bind word_length_histogram wlh_checker u_checker (.*);

### tb/word_length_histogram_tb.sv
module word_length_histogram_tb;
  import wlh_pkg::*;

  localparam int MAX_LEN = MAX_WORD_LEN_DEF;
  localparam int unsigned COUNT_LIMIT = (2 ** COUNT_BITS_DEF) - 1;
  // one full readout with the scale search, rounded up; used as the settle time
  localparam int DRAIN_CYCLES = 2 + (MAX_LEN + 1) * (COUNT_BITS_DEF + 3)
                                + 2 * COUNT_BITS_DEF + 3 + 20;
  // longest quiet spell of a correct run is one scale search plus one bin, or a drain
  localparam int WATCHDOG_LIMIT = 4 * DRAIN_CYCLES;
  localparam int RANDOM_WORDS = 40;
  localparam int IDLE_PCT = 22;

  localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_BITS-1:0] CHAR_COMMA = 8'h2C;

  typedef enum logic [1:0] {SCAN_OUTSIDE, SCAN_IN_WORD, SCAN_AFTER_APOS} scan_state_t;

  typedef struct packed {
    logic [BIN_LEN_BITS-1:0] bin_length;
    logic [FIELD_BITS-1:0]   word_count;
    logic [FIELD_BITS-1:0]   bar_length;
    logic [FIELD_BITS-1:0]   scale;
    logic                    last;
  } bin_report_t;

  // ---------------------------------------------------------------- DUT signals
  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    op = OP_TEXT;
  logic [CHAR_BITS-1:0]    char_code = '0;
  logic                    max_bar_width_we = 1'b0;
  logic [BAR_BITS-1:0]     max_bar_width = MAX_BAR_WIDTH_RESET;
  logic                    result_strobe;
  logic [BIN_LEN_BITS-1:0] bin_length;
  logic [FIELD_BITS-1:0]   word_count;
  logic [FIELD_BITS-1:0]   bar_length;
  logic [FIELD_BITS-1:0]   scale;
  logic                    last;

  word_length_histogram DUT (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .op               (op),
    .char_code        (char_code),
    .max_bar_width_we (max_bar_width_we),
    .max_bar_width    (max_bar_width),
    .result_strobe    (result_strobe),
    .bin_length       (bin_length),
    .word_count       (word_count),
    .bar_length       (bar_length),
    .scale            (scale),
    .last             (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ------------------------------------------------------- histogram predictor
  // Own copy of the scanner and the bins; overflow bin sits at index MAX_LEN.
  scan_state_t       scan_q = SCAN_OUTSIDE;
  int unsigned       word_len = 0;
  int unsigned       length_counts [MAX_LEN+1];
  int unsigned       peak_count = 0;
  logic [BAR_BITS-1:0] bar_width_q = MAX_BAR_WIDTH_RESET;

  bin_report_t expected_bins [$];

  int fail_count = 0;
  int words_sent = 0;
  int readouts = 0;
  int reports_checked = 0;
  int widths_written = 0;
  int idle_pct = IDLE_PCT;

  initial begin
    foreach (length_counts[i]) length_counts[i] = 0;
  end

  // a finished word bumps its bin; an empty pending word records nothing
  function automatic void close_word();
    int unsigned idx;
    if (word_len == 0) return;
    idx = (word_len <= MAX_LEN) ? word_len - 1 : MAX_LEN;
    if (length_counts[idx] < COUNT_LIMIT) length_counts[idx]++;
    if (length_counts[idx] > peak_count) peak_count = length_counts[idx];
    word_len = 0;
  endfunction

  function automatic void model_text_byte(input logic [CHAR_BITS-1:0] code);
    logic [CHAR_BITS-1:0] folded;
    logic is_letter;
    folded = (code >= CHAR_UP_A && code <= CHAR_UP_Z) ? code - CHAR_UP_A + CHAR_LO_A : code;
    is_letter = (folded >= CHAR_LO_A && folded <= CHAR_LO_Z);
    if (is_letter) begin
      // pending length stops one past the last real bin
      if (word_len <= MAX_LEN) word_len++;
      scan_q = SCAN_IN_WORD;
    end else if (scan_q == SCAN_IN_WORD && folded == CHAR_APOS) begin
      scan_q = SCAN_AFTER_APOS;
    end else begin
      if (scan_q != SCAN_OUTSIDE) close_word();
      scan_q = SCAN_OUTSIDE;
    end
  endfunction

  // end of text: flush, find the bar scale, queue every bin, then clear
  function automatic void model_end_of_text();
    int unsigned limit;
    int unsigned bar_scale;
    bin_report_t rep;
    close_word();
    limit = (bar_width_q == 0) ? 1 : bar_width_q;
    bar_scale = 1;
    if (peak_count > limit) begin
      bar_scale = peak_count / limit;
      if (peak_count / bar_scale > limit) bar_scale++;
    end
    for (int i = 0; i <= MAX_LEN; i++) begin
      rep.bin_length = BIN_LEN_BITS'(i + 1);
      rep.word_count = FIELD_BITS'(length_counts[i]);
      rep.bar_length = FIELD_BITS'(length_counts[i] / bar_scale);
      rep.scale      = FIELD_BITS'(bar_scale);
      rep.last       = (i == MAX_LEN);
      expected_bins.push_back(rep);
      length_counts[i] = 0;
    end
    peak_count = 0;
    word_len = 0;
    scan_q = SCAN_OUTSIDE;
    readouts++;
  endfunction

  // ------------------------------------------------------------ result checker
  // The receiver cannot stall, so every strobe is taken at the edge that ends it.
  function automatic void check_field(input string name, input logic [FIELD_BITS-1:0] want,
                                      input logic [FIELD_BITS-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  bin_report_t due;

  always @(posedge clk) begin
    if (!rst && result_strobe) begin
      if (expected_bins.size() == 0) begin
        $error("bin report with none expected: bin_length %0d word_count %0d",
               bin_length, word_count);
        fail_count++;
      end else begin
        due = expected_bins.pop_front();
        check_field("bin_length", FIELD_BITS'(due.bin_length), FIELD_BITS'(bin_length));
        check_field("word_count", due.word_count, word_count);
        check_field("bar_length", due.bar_length, bar_length);
        check_field("scale", due.scale, scale);
        check_field("last", FIELD_BITS'(due.last), FIELD_BITS'(last));
        reports_checked++;
      end
    end
  end

  // -------------------------------------------------------------- watchdog
  // Counts edges at which nothing moves: no word taken, no report, no write.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || result_strobe || max_bar_width_we) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  // -------------------------------------------------------------- driver side
  // Called just after a rising edge. Random idle cycles first, then the word is
  // held until an edge sees busy low. start stays high on return so back-to-back
  // words need no second assignment in the same step.
  task automatic send_word(input logic word_op, input logic [CHAR_BITS-1:0] code);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    op        <= word_op;
    char_code <= code;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (word_op == OP_TEXT) model_text_byte(code);
    else model_end_of_text();
    words_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(OP_TEXT, CHAR_BITS'(s[i]));
  endtask

  function automatic logic [CHAR_BITS-1:0] random_letter();
    logic [CHAR_BITS-1:0] base;
    base = $urandom_range(1) ? CHAR_UP_A : CHAR_LO_A;
    return base + CHAR_BITS'($urandom_range(25));
  endfunction

  // Sender holds off until every report is in and the block is idle, then lets
  // a full readout's worth of cycles pass in case a text word is still in flight.
  task automatic settle();
    start <= 1'b0;
    while (expected_bins.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // only ever called after settle()
  task automatic write_bar_width(input logic [BAR_BITS-1:0] w);
    max_bar_width_we <= 1'b1;
    max_bar_width    <= w;
    @(posedge clk);
    bar_width_q = w;
    widths_written++;
    max_bar_width_we <= 1'b0;
  endtask

  // ------------------------------------------------------------------- tests
  // Readout straight after reset: all bins zero, reset bar width, scale 1.
  task automatic test_empty_readout();
    send_word(OP_END, 8'hFF);
  endtask

  // Both cases, the letters at the ends of each range and their neighbours, bytes
  // above ASCII, and a word left open when end of text arrives.
  task automatic test_letter_edges();
    settle();
    write_bar_width(MAX_BAR_WIDTH_RESET);
    send_text("Az aZ");
    send_word(OP_TEXT, CHAR_UP_A - 1);
    send_word(OP_TEXT, CHAR_LO_Z);
    send_word(OP_TEXT, CHAR_UP_Z + 1);
    send_word(OP_TEXT, CHAR_LO_A);
    send_word(OP_TEXT, CHAR_LO_A - 1);
    send_word(OP_TEXT, CHAR_UP_Z);
    send_word(OP_TEXT, CHAR_LO_Z + 1);
    send_word(OP_TEXT, 8'h00);
    send_word(OP_TEXT, CHAR_UP_A);
    send_word(OP_TEXT, 8'hFF);
    send_word(OP_TEXT, CHAR_LO_A);
    send_word(OP_TEXT, 8'h80);
    send_word(OP_TEXT, CHAR_UP_Z);
    send_word(OP_END, 8'h00);
  endtask

  // Leading apostrophe ignored, contraction not counted, doubled apostrophe ends
  // the word, trailing apostrophe then punctuation or end of text.
  task automatic test_apostrophes();
    send_text("'it's don''t x'");
    send_word(OP_TEXT, CHAR_COMMA);
    send_text("ab'");
    send_word(OP_END, 8'h5A);
  endtask

  // Longest real bin, one past it, and a word well past where the length stops.
  // Sent flat out, with no idle cycles.
  task automatic test_long_words();
    idle_pct = 0;
    repeat (MAX_LEN) send_word(OP_TEXT, CHAR_LO_A);
    send_word(OP_TEXT, CHAR_SPACE);
    repeat (MAX_LEN + 1) send_word(OP_TEXT, CHAR_UP_Z);
    send_word(OP_TEXT, CHAR_SPACE);
    repeat (MAX_LEN + 6) send_word(OP_TEXT, random_letter());
    send_word(OP_END, 8'h00);
    idle_pct = IDLE_PCT;
  endtask

  // Scale search: narrowest bar, zero taken as one, a quotient that needs the
  // extra step (8 words against 3), and the widest bar.
  task automatic test_bar_scale();
    settle();
    write_bar_width(8'd1);
    send_text("a b c ab");
    send_word(OP_END, 8'h00);
    settle();
    write_bar_width(8'd0);
    send_text("q w e rt yu");
    send_word(OP_END, 8'h00);
    settle();
    write_bar_width(8'd3);
    send_text("a b c d e f g h ij");
    send_word(OP_END, 8'h00);
    settle();
    write_bar_width(8'd255);
    send_text("ab cd e");
    send_word(OP_END, 8'h00);
  endtask

  // Mostly well-formed text with random letters, lengths, separators and noise bytes,
  // random bar widths between readouts; phase 1 and every fourth after it go flat out.
  task automatic test_random_text();
    int first;
    int phase;
    int n_words;
    int len;
    first = words_sent;
    phase = 0;
    while (words_sent - first < RANDOM_WORDS) begin
      idle_pct = (phase % 4 == 1) ? 0 : IDLE_PCT;
      n_words = $urandom_range(12, 2);
      for (int k = 0; k < n_words; k++) begin
        if ($urandom_range(99) < 15) send_word(OP_TEXT, CHAR_BITS'($urandom_range(255)));
        // most words short, a few long, some of those into the overflow bin
        len = ($urandom_range(9) == 0) ? $urandom_range(MAX_LEN + 8, MAX_LEN - 3)
                                       : $urandom_range(8, 1);
        for (int j = 0; j < len; j++) begin
          send_word(OP_TEXT, random_letter());
          if (j + 1 < len && $urandom_range(19) == 0) send_word(OP_TEXT, CHAR_APOS);
        end
        case ($urandom_range(9))
          0: begin
            send_word(OP_TEXT, CHAR_APOS);
            send_word(OP_TEXT, CHAR_APOS);
          end
          1: send_word(OP_TEXT, CHAR_APOS);
          default: ;
        endcase
        if ($urandom_range(9) < 7) send_word(OP_TEXT, CHAR_SPACE);
        else send_word(OP_TEXT, CHAR_BITS'($urandom_range(255)));
      end
      if ($urandom_range(4) != 0) send_word(OP_END, CHAR_BITS'($urandom_range(255)));
      if ($urandom_range(2) == 0) begin
        settle();
        case ($urandom_range(5))
          0: write_bar_width(8'd0);
          1: write_bar_width(8'd1);
          2: write_bar_width(8'd255);
          3: write_bar_width(BAR_BITS'($urandom_range(255, 1)));
          default: write_bar_width(BAR_BITS'($urandom_range(6, 2)));
        endcase
      end
      phase++;
    end
    idle_pct = IDLE_PCT;
    send_word(OP_END, CHAR_BITS'($urandom_range(255)));
  endtask

  // ------------------------------------------------------------ test sequence
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_empty_readout();
    test_letter_edges();
    test_apostrophes();
    test_long_words();
    test_bar_scale();
    test_random_text();
    settle();
    $display("Sent %0d words with %0d readouts; %0d bin reports checked.",
             words_sent, readouts, reports_checked);
    $display("Bar width written %0d times, including 0, 1 and 255.", widths_written);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
